FILE: design/btr_pkg.sv
`default_nettype none

package btr_pkg;

    // Request codes on req_type
    localparam logic REQ_MEASURE = 1'b0;
    localparam logic REQ_DRAW    = 1'b1;

    // Configuration register indexes
    localparam logic [1:0] CFG_BRIGHTNESS   = 2'd0;
    localparam logic [1:0] CFG_LINE_Y       = 2'd1;
    localparam logic [1:0] CFG_SCREEN_WIDTH = 2'd2;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 10;

    // Character codes with special handling
    localparam logic [7:0] CHAR_SPACE   = 8'h20;
    localparam logic [7:0] CHAR_EXCLAIM = 8'h21;
    localparam logic [7:0] CHAR_APOS    = 8'h27;
    localparam logic [7:0] CHAR_COMMA   = 8'h2C;
    localparam logic [7:0] CHAR_PERIOD  = 8'h2E;
    localparam logic [7:0] CHAR_AT      = 8'h40;
    localparam logic [7:0] CHAR_A       = 8'h41;
    localparam logic [7:0] CHAR_Z       = 8'h5A;

    // Glyph slots after the letters
    localparam logic [4:0] SLOT_COMMA  = 5'd26;
    localparam logic [4:0] SLOT_PERIOD = 5'd27;
    localparam logic [4:0] SLOT_AT     = 5'd28;
    localparam logic [4:0] SLOT_APOS   = 5'd29;
    localparam logic [4:0] SLOT_EXCL   = 5'd30;

    localparam int GLYPH_COUNT = 31;
    localparam int GLYPH_ROWS  = 7;
    localparam int GLYPH_COLS  = 5;

    // Advances in pixels
    localparam logic [2:0] ADV_WIDE   = 3'd6;
    localparam logic [2:0] ADV_NARROW = 3'd4;
    localparam logic [2:0] ADV_PERIOD = 3'd3;

    // Text colour at full level
    localparam logic [7:0] COLOR_RED   = 8'd235;
    localparam logic [7:0] COLOR_GREEN = 8'd230;
    localparam logic [7:0] COLOR_BLUE  = 8'd215;

    // 5x7 glyphs, bit 0 of each row is the leftmost column
    localparam logic [4:0] GLYPH_ROM [GLYPH_COUNT][GLYPH_ROWS] = '{
        '{5'h0E, 5'h11, 5'h11, 5'h1F, 5'h11, 5'h11, 5'h11},
        '{5'h0F, 5'h11, 5'h11, 5'h0F, 5'h11, 5'h11, 5'h0F},
        '{5'h0E, 5'h11, 5'h01, 5'h01, 5'h01, 5'h11, 5'h0E},
        '{5'h0F, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0F},
        '{5'h1F, 5'h01, 5'h01, 5'h0F, 5'h01, 5'h01, 5'h1F},
        '{5'h1F, 5'h01, 5'h01, 5'h0F, 5'h01, 5'h01, 5'h01},
        '{5'h0E, 5'h11, 5'h01, 5'h1D, 5'h11, 5'h11, 5'h0E},
        '{5'h11, 5'h11, 5'h11, 5'h1F, 5'h11, 5'h11, 5'h11},
        '{5'h1F, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h1F},
        '{5'h1C, 5'h08, 5'h08, 5'h08, 5'h08, 5'h09, 5'h06},
        '{5'h11, 5'h09, 5'h05, 5'h03, 5'h05, 5'h09, 5'h11},
        '{5'h01, 5'h01, 5'h01, 5'h01, 5'h01, 5'h01, 5'h1F},
        '{5'h11, 5'h1B, 5'h15, 5'h15, 5'h11, 5'h11, 5'h11},
        '{5'h11, 5'h13, 5'h15, 5'h19, 5'h11, 5'h11, 5'h11},
        '{5'h0E, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E},
        '{5'h0F, 5'h11, 5'h11, 5'h0F, 5'h01, 5'h01, 5'h01},
        '{5'h0E, 5'h11, 5'h11, 5'h11, 5'h15, 5'h09, 5'h16},
        '{5'h0F, 5'h11, 5'h11, 5'h0F, 5'h05, 5'h09, 5'h11},
        '{5'h1E, 5'h01, 5'h01, 5'h0E, 5'h10, 5'h10, 5'h0F},
        '{5'h1F, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04},
        '{5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E},
        '{5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0A, 5'h04},
        '{5'h11, 5'h11, 5'h11, 5'h15, 5'h15, 5'h1B, 5'h11},
        '{5'h11, 5'h11, 5'h0A, 5'h04, 5'h0A, 5'h11, 5'h11},
        '{5'h11, 5'h11, 5'h0A, 5'h04, 5'h04, 5'h04, 5'h04},
        '{5'h1F, 5'h10, 5'h08, 5'h04, 5'h02, 5'h01, 5'h1F},
        '{5'h00, 5'h00, 5'h00, 5'h00, 5'h04, 5'h04, 5'h02},
        '{5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h01, 5'h01},
        '{5'h0E, 5'h11, 5'h1D, 5'h15, 5'h1D, 5'h01, 5'h0E},
        '{5'h04, 5'h04, 5'h02, 5'h00, 5'h00, 5'h00, 5'h00},
        '{5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h00, 5'h04}
    };

    typedef struct packed {
        logic       valid;
        logic [4:0] idx;
    } glyph_sel_t;

    // Controller to datapath
    typedef struct packed {
        logic load;
        logic step;
    } btr_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic start_run;
        logic out_free;
        logic last;
    } btr_status_t;

    // Map a character code to its glyph slot
    function automatic glyph_sel_t btr_glyph_sel(logic [7:0] code);
        glyph_sel_t sel;
        sel.valid = 1'b1;
        sel.idx   = 5'd0;
        if (code >= CHAR_A && code <= CHAR_Z) begin
            sel.idx = 5'(code - CHAR_A);
        end else if (code == CHAR_COMMA) begin
            sel.idx = SLOT_COMMA;
        end else if (code == CHAR_PERIOD) begin
            sel.idx = SLOT_PERIOD;
        end else if (code == CHAR_AT) begin
            sel.idx = SLOT_AT;
        end else if (code == CHAR_APOS) begin
            sel.idx = SLOT_APOS;
        end else if (code == CHAR_EXCLAIM) begin
            sel.idx = SLOT_EXCL;
        end else begin
            sel.valid = 1'b0;
        end
        return sel;
    endfunction

    // Pen advance for a character code
    function automatic logic [2:0] btr_advance(logic [7:0] code);
        logic [2:0] adv;
        adv = ADV_WIDE;
        if (code == CHAR_SPACE || code == CHAR_APOS || code == CHAR_EXCLAIM) begin
            adv = ADV_NARROW;
        end else if (code == CHAR_PERIOD) begin
            adv = ADV_PERIOD;
        end
        return adv;
    endfunction

    // One glyph row; rows past the bottom read as blank
    function automatic logic [4:0] btr_glyph_row(logic [4:0] g, logic [2:0] r);
        logic [4:0] bits;
        bits = 5'd0;
        if (int'(g) < GLYPH_COUNT && int'(r) < GLYPH_ROWS) begin
            bits = GLYPH_ROM[g][r];
        end
        return bits;
    endfunction

    // Lowest row of a glyph that holds a lit pixel
    function automatic logic [2:0] btr_last_row(logic [4:0] g);
        logic [2:0] last;
        last = 3'd0;
        for (int i = 0; i < GLYPH_ROWS; i++) begin
            if (btr_glyph_row(g, 3'(i)) != 5'd0) begin
                last = 3'(i);
            end
        end
        return last;
    endfunction

endpackage

`default_nettype wire

FILE: design/btr_ctrl.sv
`default_nettype none

module btr_ctrl (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire btr_pkg::btr_status_t status,
    output btr_pkg::btr_cmd_t         cmd
);

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Take items in idle, step the scan while the output slot is free
    always_comb begin
        state_next = state_reg;
        s_ready    = 1'b0;
        cmd.load   = 1'b0;
        cmd.step   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
                if (s_valid && status.start_run) begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN: begin
                cmd.step = status.out_free;
                if (status.out_free && status.last) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

FILE: design/btr_dp.sv
`default_nettype none

module btr_dp #(
    parameter int MAX_LINE_CHARS = 64
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire btr_pkg::btr_cmd_t                  cmd,
    output btr_pkg::btr_status_t                    status,
    input  wire logic                               cfg_valid,
    input  wire logic [btr_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  wire logic [btr_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  wire logic                               s_req_type,
    input  wire logic [7:0]                         s_char_code,
    input  wire logic                               s_line_start,
    output logic                                    m_valid,
    input  wire logic                               m_ready,
    output logic signed [10:0]                      m_run_x,
    output logic [9:0]                              m_run_y,
    output logic [2:0]                              m_run_width,
    output logic [7:0]                              m_red,
    output logic [7:0]                              m_green,
    output logic [7:0]                              m_blue,
    output logic                                    m_last_run
);

    localparam int CapRaw = MAX_LINE_CHARS * 6;
    localparam logic [9:0] MEAS_CAP = (CapRaw > 1023) ? 10'd1023 : 10'(CapRaw);

    // Configuration and line state
    logic [7:0]  brightness_reg;
    logic [8:0]  line_y_reg;
    logic [9:0]  screen_width_reg;
    logic [9:0]  measured_width_reg;
    logic [10:0] pen_x_reg;

    // Scan state for the current glyph
    logic [4:0]  glyph_reg;
    logic [2:0]  row_reg;
    logic [4:0]  rem_reg;
    logic [2:0]  adv_reg;
    logic [7:0]  red_reg;
    logic [7:0]  green_reg;
    logic [7:0]  blue_reg;

    // Output slot
    logic        m_valid_reg;
    logic [10:0] run_x_reg;
    logic [9:0]  run_y_reg;
    logic [2:0]  run_width_reg;
    logic [7:0]  out_red_reg;
    logic [7:0]  out_green_reg;
    logic [7:0]  out_blue_reg;
    logic        last_run_reg;

    btr_pkg::glyph_sel_t in_sel;
    logic [2:0]  in_adv;
    logic        renderable;
    logic [10:0] meas_sum;
    logic [9:0]  meas_next;
    logic [9:0]  span;
    logic signed [11:0] center_diff;
    logic signed [11:0] center_half;
    logic [10:0] pen_base;
    logic [2:0]  run_start;
    logic [2:0]  run_len;
    logic [4:0]  run_mask;
    logic        run_done;
    logic [4:0]  rem_after;
    logic [2:0]  row_inc;
    logic [2:0]  last_row;
    logic        emit;
    logic        run_last;
    logic        out_free;
    logic [16:0] red_scaled;
    logic [16:0] green_scaled;
    logic [16:0] blue_scaled;

    // Scale a colour by level/255 with an exact reciprocal for 16-bit products
    function automatic logic [16:0] scale255(logic [7:0] coef, logic [7:0] level);
        logic [16:0] prod;
        prod = 17'(coef) * 17'(level);
        return (prod + 17'd1 + (prod >> 8)) >> 8;
    endfunction

    assign in_sel     = btr_pkg::btr_glyph_sel(s_char_code);
    assign in_adv     = btr_pkg::btr_advance(s_char_code);
    assign renderable = (s_req_type == btr_pkg::REQ_DRAW) && in_sel.valid
                        && (brightness_reg != 8'd0);

    // Sum advances, saturating at the line capacity
    assign meas_sum  = (s_line_start ? 11'd0 : {1'b0, measured_width_reg}) + 11'(in_adv);
    assign meas_next = (meas_sum > 11'(MEAS_CAP)) ? MEAS_CAP : meas_sum[9:0];

    // Center the line: (width - (measured - 1)) / 2, toward zero
    assign span        = (measured_width_reg != 10'd0) ? measured_width_reg - 10'd1 : 10'd0;
    assign center_diff = $signed({2'b00, screen_width_reg}) - $signed({2'b00, span});
    assign center_half = center_diff[11] ? ((center_diff + 12'sd1) >>> 1) : (center_diff >>> 1);
    assign pen_base    = s_line_start ? center_half[10:0] : pen_x_reg;

    assign red_scaled   = scale255(btr_pkg::COLOR_RED, brightness_reg);
    assign green_scaled = scale255(btr_pkg::COLOR_GREEN, brightness_reg);
    assign blue_scaled  = scale255(btr_pkg::COLOR_BLUE, brightness_reg);

    // Find the leftmost run in what remains of the row
    always_comb begin
        run_start = 3'd0;
        run_len   = 3'd0;
        run_mask  = 5'd0;
        run_done  = 1'b0;
        for (int i = 0; i < btr_pkg::GLYPH_COLS; i++) begin
            if (rem_reg[i] && !run_done) begin
                if (run_len == 3'd0) begin
                    run_start = 3'(i);
                end
                run_len     = run_len + 3'd1;
                run_mask[i] = 1'b1;
            end else if (run_len != 3'd0) begin
                run_done = 1'b1;
            end
        end
    end

    assign rem_after = rem_reg & ~run_mask;
    assign row_inc   = row_reg + 3'd1;
    assign last_row  = btr_pkg::btr_last_row(glyph_reg);
    assign out_free  = !m_valid_reg || m_ready;
    assign emit      = cmd.step && (rem_reg != 5'd0);
    assign run_last  = (rem_after == 5'd0) && (row_reg == last_row);

    assign status.start_run = renderable;
    assign status.out_free  = out_free;
    assign status.last      = (rem_reg != 5'd0) && run_last;

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            brightness_reg   <= 8'd255;
            line_y_reg       <= 9'd0;
            screen_width_reg <= 10'd320;
        end else if (cfg_valid) begin
            case (cfg_index)
                btr_pkg::CFG_BRIGHTNESS:   brightness_reg   <= cfg_data[7:0];
                btr_pkg::CFG_LINE_Y:       line_y_reg       <= cfg_data[8:0];
                btr_pkg::CFG_SCREEN_WIDTH: screen_width_reg <= cfg_data[9:0];
                default: begin
                end
            endcase
        end
    end

    // Measure and pen state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            measured_width_reg <= 10'd0;
            pen_x_reg          <= 11'd0;
        end else if (cmd.load) begin
            if (s_req_type == btr_pkg::REQ_MEASURE) begin
                measured_width_reg <= meas_next;
            end else if (renderable) begin
                pen_x_reg <= pen_base;
            end else begin
                pen_x_reg <= pen_base + 11'(in_adv);
            end
        end else if (emit && run_last) begin
            pen_x_reg <= pen_x_reg + 11'(adv_reg);
        end
    end

    // Glyph scan: load on every item taken, then drop one run or one blank row per step
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            glyph_reg <= in_sel.idx;
            row_reg   <= 3'd0;
            rem_reg   <= btr_pkg::btr_glyph_row(in_sel.idx, 3'd0);
            adv_reg   <= in_adv;
            red_reg   <= red_scaled[7:0];
            green_reg <= green_scaled[7:0];
            blue_reg  <= blue_scaled[7:0];
        end else if (cmd.step) begin
            if (rem_reg == 5'd0 || (rem_after == 5'd0 && !run_last)) begin
                row_reg <= row_inc;
                rem_reg <= btr_pkg::btr_glyph_row(glyph_reg, row_inc);
            end else begin
                rem_reg <= rem_after;
            end
        end
    end

    // Output slot: fill on a run, empty when taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            run_x_reg     <= pen_x_reg + 11'(run_start);
            run_y_reg     <= {1'b0, line_y_reg} + 10'(row_reg);
            run_width_reg <= run_len;
            out_red_reg   <= red_reg;
            out_green_reg <= green_reg;
            out_blue_reg  <= blue_reg;
            last_run_reg  <= run_last;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_run_x     = $signed(run_x_reg);
    assign m_run_y     = run_y_reg;
    assign m_run_width = run_width_reg;
    assign m_red       = out_red_reg;
    assign m_green     = out_green_reg;
    assign m_blue      = out_blue_reg;
    assign m_last_run  = last_run_reg;

endmodule

`default_nettype wire

FILE: design/bitmap_text_run_renderer.sv
`default_nettype none

// Bitmap text run renderer: draws one line of 5x7 text (A-Z , . @ ' !) as
// horizontal runs of lit pixels. Send the line once with req_type 0 to measure
// it, then again with req_type 1 to draw; line_start marks the first character
// of each pass, and the first draw character centers the line on screen_width.
// A measure item only adds its advance to the measured width, and a character
// with no glyph (or brightness 0) produces nothing but a pen advance. A drawn
// character is loaded, then the scanner steps through each run and each blank
// glyph row above its last run, holding while a full output register waits on
// m_ready; the glyph scanner emits at most one run per cycle into a single
// output register, and the next item is taken as soon as the last run of the
// current character sits in that register. Runs come row by row, top to
// bottom, left to right; last_run flags the final run of a character.
// Configuration writes are accepted in any cycle but must only be made while
// the block is idle.
module bitmap_text_run_renderer #(
    parameter int MAX_LINE_CHARS = 64
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [btr_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  wire logic [btr_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  wire logic                               s_valid,
    output logic                                    s_ready,
    input  wire logic                               s_req_type,
    input  wire logic [7:0]                         s_char_code,
    input  wire logic                               s_line_start,
    output logic                                    m_valid,
    input  wire logic                               m_ready,
    output logic signed [10:0]                      m_run_x,
    output logic [9:0]                              m_run_y,
    output logic [2:0]                              m_run_width,
    output logic [7:0]                              m_red,
    output logic [7:0]                              m_green,
    output logic [7:0]                              m_blue,
    output logic                                    m_last_run
);

    btr_pkg::btr_cmd_t    cmd;
    btr_pkg::btr_status_t status;

    assign cfg_ready = 1'b1;

    btr_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    btr_dp #(
        .MAX_LINE_CHARS (MAX_LINE_CHARS)
    ) u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .status       (status),
        .cfg_valid    (cfg_valid),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .s_req_type   (s_req_type),
        .s_char_code  (s_char_code),
        .s_line_start (s_line_start),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_run_x      (m_run_x),
        .m_run_y      (m_run_y),
        .m_run_width  (m_run_width),
        .m_red        (m_red),
        .m_green      (m_green),
        .m_blue       (m_blue),
        .m_last_run   (m_last_run)
    );

endmodule

`default_nettype wire
